>>> design/dabb_pkg.sv
// dabb_pkg: shared widths, constants and control types of the depth adaptive box blur
// used by the channel interfaces, the controller, the datapath and the top level
package dabb_pkg;

   localparam int CHAN_W          = 8;
   localparam int PIXEL_W         = 3 * CHAN_W;
   localparam int DEPTH_W         = 20;
   localparam int WIDTH_REG_W     = 13;
   localparam int ROW_W           = 14;
   localparam int MIN_SIZE        = 5;
   localparam int MAX_HEIGHT      = 8192;
   localparam int DEPTH_SCALE_NUM = 18;
   localparam int DEPTH_SCALE_DEN = 25600;
   localparam int SCALED_W        = DEPTH_W + 5;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 20;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(1920);
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = ROW_W'(1080);
   localparam logic [DEPTH_W-1:0]     FOCUS_RESET  = DEPTH_W'(3072);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FOCUS_DEPTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic ready;
      logic mul;
      logic check;
      logic rd_centre;
      logic centre;
      logic rad;
      logic win;
      logic div_start;
      logic out_try;
   } dabb_cmd_type;

   typedef struct packed {
      logic due;
      logic mod_done;
      logic pass;
      logic win_last;
      logic div_done;
      logic out_free;
   } dabb_status_type;

endpackage

>>> design/dabb_if.sv
// dabb_req_if and dabb_rsp_if: valid/ready channels of the blur unit
// depends on dabb_pkg for field widths
interface dabb_req_if import dabb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [CHAN_W-1:0]  red_in;
   logic [CHAN_W-1:0]  green_in;
   logic [CHAN_W-1:0]  blue_in;
   logic [DEPTH_W-1:0] pixel_depth;

   modport source (output valid, mode, red_in, green_in, blue_in, pixel_depth, input ready);
   modport sink   (input valid, mode, red_in, green_in, blue_in, pixel_depth, output ready);
endinterface

interface dabb_rsp_if import dabb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

>>> design/dabb_divider.sv
// dabb_divider: restoring divider, one quotient bit per cycle
// no package dependencies
module dabb_divider #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W:0]    trial_in;
   logic [DIVISOR_W:0]    diff_in;
   logic                  fits_in;

   assign trial_in = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits_in  = trial_in >= {1'b0, div_ff};
   assign diff_in  = trial_in - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end else begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff && cnt_ff != '0) begin
         rem_ff <= fits_in ? diff_in[DIVISOR_W-1:0] : trial_in[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits_in};
      end
   end

   assign done     = busy_ff && cnt_ff == '0;
   assign quotient = quo_ff;

endmodule

>>> design/dabb_ctrl.sv
// dabb_ctrl: sequencer of the blur unit, one item at a time
// depends on dabb_pkg for the command and status types
module dabb_ctrl import dabb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  dabb_status_type status,
   output dabb_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_MOD,
      ST_CRD,
      ST_CTR,
      ST_RAD,
      ST_WIN,
      ST_FLUSH,
      ST_DGO,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type    state_ff;
   state_type    state_in;
   dabb_cmd_type cmd_ff;
   dabb_cmd_type cmd_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid && cmd_ff.ready) state_in = ST_MUL;
         ST_MUL:   state_in = ST_CHECK;
         ST_CHECK: state_in = status.due ? ST_MOD : ST_IDLE;
         ST_MOD:   if (status.mod_done) state_in = ST_CRD;
         ST_CRD:   state_in = ST_CTR;
         ST_CTR:   state_in = ST_RAD;
         ST_RAD:   state_in = status.pass ? ST_OUT : ST_WIN;
         ST_WIN:   if (status.win_last) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_DGO;
         ST_DGO:   state_in = ST_DIV;
         ST_DIV:   if (status.div_done) state_in = ST_OUT;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in = '0;
      case (state_in)
         ST_IDLE:  cmd_in.ready     = 1'b1;
         ST_MUL:   cmd_in.mul       = 1'b1;
         ST_CHECK: cmd_in.check     = 1'b1;
         ST_CRD:   cmd_in.rd_centre = 1'b1;
         ST_CTR:   cmd_in.centre    = 1'b1;
         ST_RAD:   cmd_in.rad       = 1'b1;
         ST_WIN:   cmd_in.win       = 1'b1;
         ST_DGO:   cmd_in.div_start = 1'b1;
         ST_OUT:   cmd_in.out_try   = 1'b1;
         default:  cmd_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '{ready: 1'b1, default: 1'b0};
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

>>> design/dabb_datapath.sv
// dabb_datapath: line stores, stream counters, window walk, sums and output register
// depends on dabb_pkg and dabb_divider
module dabb_datapath import dabb_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_RADIUS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dabb_cmd_type                     cmd,
   output dabb_status_type                  status,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   img_width,
   input  logic [ROW_W-1:0]                 img_height,
   input  logic [DEPTH_W-1:0]               focus,
   input  logic                             req_accept,
   input  logic                             req_mode,
   input  logic [CHAN_W-1:0]                req_red,
   input  logic [CHAN_W-1:0]                req_green,
   input  logic [CHAN_W-1:0]                req_blue,
   input  logic [DEPTH_W-1:0]               req_depth,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [CHAN_W-1:0]                rsp_red,
   output logic [CHAN_W-1:0]                rsp_green,
   output logic [CHAN_W-1:0]                rsp_blue,
   output logic                             rsp_frame_end
);

   localparam int SLOTS      = 2 * MAX_RADIUS + 2;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int MOD_SHIFT  = ROW_W + 5;
   localparam int RECIP      = ((1 << MOD_SHIFT) + SLOTS - 1) / SLOTS;
   localparam int MPROD_W    = ROW_W + MOD_SHIFT;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int W_W        = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH      = SLOTS * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
   localparam int OFF_W      = RAD_W + 1;
   localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
   localparam int CNT_MAX    = SIDE_MAX * SIDE_MAX;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);
   localparam int SUM_W      = $clog2(CNT_MAX * 255 + 1);
   localparam int PROD_W     = ROW_W + W_W + 1;
   localparam int SROW_W     = ROW_W + 2;
   localparam int SCOL_W     = W_W + 2;
   localparam int SSLOT_W    = SLOT_W + 3;

   // stream position
   logic [COL_W-1:0]  in_col_ff;
   logic [ROW_W-1:0]  in_row_ff;
   logic [SLOT_W-1:0] in_slot_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W:0]    in_col_inc;
   logic [COL_W:0]    out_col_inc;
   logic [SLOT_W-1:0] in_slot_inc;

   // line stores
   logic [PIXEL_W-1:0] pix_mem [DEPTH];
   logic [DEPTH_W-1:0] dep_mem [DEPTH];
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  centre_addr;
   logic [ADDR_W-1:0]  win_addr;
   logic [PIXEL_W-1:0] pix_rd_ff;
   logic [DEPTH_W-1:0] dep_rd_ff;

   // lag test and centre
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] recv_in;
   logic [PROD_W-1:0] lag_in;
   logic              due_in;
   logic [ROW_W-1:0]  cy_in;
   logic [COL_W-1:0]  cx_in;
   logic              last_in;
   logic [ROW_W-1:0]  cy_ff;
   logic [COL_W-1:0]  cx_ff;
   logic              last_ff;
   logic [SLOT_W-1:0] slot_c_ff;

   // radius
   logic [PIXEL_W-1:0]  centre_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic                border_ff;
   logic [DEPTH_W-1:0]  diff_in;
   logic [RAD_W-1:0]    radius_in;
   logic                pass_in;
   logic [RAD_W-1:0]    radius_ff;

   // window walk
   logic signed [OFF_W-1:0]   dy_ff;
   logic signed [OFF_W-1:0]   dx_ff;
   logic signed [OFF_W-1:0]   rad_s;
   logic signed [OFF_W-1:0]   off_y;
   logic signed [SROW_W-1:0]  sy_raw;
   logic signed [SCOL_W-1:0]  sx_raw;
   logic signed [SSLOT_W-1:0] slot_raw;
   logic [SLOT_W-1:0]         slot_w;
   logic [COL_W-1:0]          sx_w;
   logic                      issue_ff;
   logic [SUM_W-1:0]          sum_r_ff;
   logic [SUM_W-1:0]          sum_g_ff;
   logic [SUM_W-1:0]          sum_b_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          side_in;

   // row slot, dividers and result
   logic                  mod_start;
   logic                  mod_go_ff;
   logic                  mod_done_ff;
   logic                  mod_done;
   logic [MPROD_W-1:0]    mod_prod;
   logic [ROW_W-1:0]      mod_quo_ff;
   logic [ROW_W-1:0]      mod_rem;
   logic                  div_done_r;
   logic                  div_done_g;
   logic                  div_done_b;
   logic [SUM_W-1:0]      quo_r;
   logic [SUM_W-1:0]      quo_g;
   logic [SUM_W-1:0]      quo_b;
   logic [PIXEL_W-1:0]    result_ff;
   logic                  out_free;
   logic                  out_load;
   logic                  rsp_valid_ff;
   logic [PIXEL_W-1:0]    rsp_pix_ff;
   logic                  rsp_last_ff;

   // input side
   assign in_col_inc  = {1'b0, in_col_ff} + 1'b1;
   assign in_slot_inc = (in_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_ff + 1'b1;
   assign wr_en   = req_accept && !req_mode && in_row_ff < img_height
                    && W_W'(in_col_ff) < img_width;
   assign wr_addr = ADDR_W'(in_slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);

   // lag and output position
   assign recv_in = prod_ff + PROD_W'(in_col_ff);
   assign lag_in  = PROD_W'(img_width) * PROD_W'(MAX_RADIUS) + PROD_W'(MAX_RADIUS);
   assign due_in  = recv_in > lag_in;
   assign cy_in   = (out_row_ff < img_height) ? out_row_ff : img_height - 1'b1;
   assign cx_in   = (W_W'(out_col_ff) < img_width) ? out_col_ff
                                                    : COL_W'(img_width - 1'b1);
   assign last_in = out_row_ff >= img_height - 1'b1
                    && W_W'(out_col_ff) >= img_width - 1'b1;
   assign out_col_inc = {1'b0, out_col_ff} + 1'b1;
   assign mod_start   = cmd.check && due_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_slot_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (req_accept) begin
         if (in_col_inc >= (COL_W+1)'(img_width)) begin
            in_col_ff  <= '0;
            in_row_ff  <= in_row_ff + 1'b1;
            in_slot_ff <= in_slot_inc;
         end else begin
            in_col_ff <= in_col_inc[COL_W-1:0];
         end
      end else if (cmd.check && due_in) begin
         if (last_in) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            in_slot_ff <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (out_col_inc >= (COL_W+1)'(img_width)) begin
            out_col_ff <= '0;
            out_row_ff <= out_row_ff + 1'b1;
         end else begin
            out_col_ff <= out_col_inc[COL_W-1:0];
         end
      end
   end

   // row slot of the centre by reciprocal multiply: quotient, then remainder
   assign mod_prod = MPROD_W'(cy_ff) * MPROD_W'(RECIP);
   assign mod_rem  = cy_ff - ROW_W'(mod_quo_ff * ROW_W'(SLOTS));
   assign mod_done = mod_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_go_ff   <= 1'b0;
         mod_done_ff <= 1'b0;
      end else begin
         mod_go_ff   <= mod_start;
         mod_done_ff <= mod_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(in_row_ff) * PROD_W'(img_width);
      end
      if (mod_start) begin
         cy_ff   <= cy_in;
         cx_ff   <= cx_in;
         last_ff <= last_in;
      end
      if (mod_go_ff) begin
         mod_quo_ff <= mod_prod[MPROD_W-1 -: ROW_W];
      end
      if (mod_done) begin
         slot_c_ff <= mod_rem[SLOT_W-1:0];
      end
   end

   // memories
   assign centre_addr = ADDR_W'(slot_c_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx_ff);
   assign rd_addr     = cmd.win ? win_addr : centre_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem[wr_addr] <= {req_red, req_green, req_blue};
         dep_mem[wr_addr] <= req_depth;
      end
      pix_rd_ff <= pix_mem[rd_addr];
      dep_rd_ff <= dep_mem[rd_addr];
   end

   // centre, border and radius
   assign diff_in = (dep_rd_ff >= focus) ? dep_rd_ff - focus : focus - dep_rd_ff;

   always_comb begin
      radius_in = '0;
      for (int k = 1; k <= MAX_RADIUS; k++) begin
         radius_in = radius_in
                     + RAD_W'(scaled_ff >= SCALED_W'(k * DEPTH_SCALE_DEN));
      end
   end

   assign pass_in = border_ff || radius_in == '0;
   assign rad_s   = $signed(OFF_W'(radius_ff));

   always_ff @(posedge clock) begin
      if (cmd.centre) begin
         centre_ff <= pix_rd_ff;
         scaled_ff <= SCALED_W'(diff_in) * SCALED_W'(DEPTH_SCALE_NUM);
         border_ff <= cy_ff < ROW_W'(2) || ({1'b0, cy_ff} + 2'd2) >= {1'b0, img_height}
                      || cx_ff < COL_W'(2)
                      || ((W_W+1)'(cx_ff) + 2'd2) >= (W_W+1)'(img_width);
      end
   end

   // window address
   always_comb begin
      sy_raw = $signed(SROW_W'(cy_ff)) + SROW_W'(dy_ff);
      if (sy_raw < 0) begin
         off_y = -$signed(OFF_W'(cy_ff));
      end else if (sy_raw > $signed(SROW_W'(img_height - 1'b1))) begin
         off_y = OFF_W'(img_height - 1'b1 - cy_ff);
      end else begin
         off_y = dy_ff;
      end
      slot_raw = $signed(SSLOT_W'(slot_c_ff)) + SSLOT_W'(off_y);
      if (slot_raw < 0) begin
         slot_w = SLOT_W'(slot_raw + SSLOT_W'(SLOTS));
      end else if (slot_raw >= $signed(SSLOT_W'(SLOTS))) begin
         slot_w = SLOT_W'(slot_raw - SSLOT_W'(SLOTS));
      end else begin
         slot_w = SLOT_W'(slot_raw);
      end
      sx_raw = $signed(SCOL_W'(cx_ff)) + SCOL_W'(dx_ff);
      if (sx_raw < 0) begin
         sx_w = '0;
      end else if (sx_raw > $signed(SCOL_W'(img_width - 1'b1))) begin
         sx_w = COL_W'(img_width - 1'b1);
      end else begin
         sx_w = COL_W'(sx_raw);
      end
      win_addr = ADDR_W'(slot_w) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_w);
   end

   assign status.win_last = dx_ff == rad_s && dy_ff == rad_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
      end else begin
         issue_ff <= cmd.win;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rad) begin
         if (pass_in) begin
            result_ff <= centre_ff;
         end else begin
            radius_ff <= radius_in;
            dy_ff     <= -$signed(OFF_W'(radius_in));
            dx_ff     <= -$signed(OFF_W'(radius_in));
            sum_r_ff  <= '0;
            sum_g_ff  <= '0;
            sum_b_ff  <= '0;
         end
      end else begin
         if (cmd.win) begin
            if (dx_ff == rad_s) begin
               dx_ff <= -rad_s;
               dy_ff <= dy_ff + 1'b1;
            end else begin
               dx_ff <= dx_ff + 1'b1;
            end
         end
         if (issue_ff) begin
            sum_r_ff <= sum_r_ff + SUM_W'(pix_rd_ff[PIXEL_W-1 -: CHAN_W]);
            sum_g_ff <= sum_g_ff + SUM_W'(pix_rd_ff[CHAN_W +: CHAN_W]);
            sum_b_ff <= sum_b_ff + SUM_W'(pix_rd_ff[CHAN_W-1:0]);
         end
         if (div_done_r) begin
            result_ff <= {quo_r[CHAN_W-1:0], quo_g[CHAN_W-1:0], quo_b[CHAN_W-1:0]};
         end
      end
   end

   // mean
   assign side_in  = CNT_W'({radius_ff, 1'b1});
   assign count_in = side_in * side_in;

   dabb_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_red (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .dividend (sum_r_ff), .divisor (count_in),
      .done (div_done_r), .quotient (quo_r)
   );

   dabb_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_green (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .dividend (sum_g_ff), .divisor (count_in),
      .done (div_done_g), .quotient (quo_g)
   );

   dabb_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_blue (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .dividend (sum_b_ff), .divisor (count_in),
      .done (div_done_b), .quotient (quo_b)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = cmd.out_try && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pix_ff  <= result_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.due      = due_in;
   assign status.mod_done = mod_done;
   assign status.pass     = pass_in;
   assign status.div_done = div_done_r && div_done_g && div_done_b;
   assign status.out_free = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = rsp_pix_ff[PIXEL_W-1 -: CHAN_W];
   assign rsp_green     = rsp_pix_ff[CHAN_W +: CHAN_W];
   assign rsp_blue      = rsp_pix_ff[CHAN_W-1:0];
   assign rsp_frame_end = rsp_last_ff;

endmodule

>>> design/depth_adaptive_box_blur_unit.sv
// depth_adaptive_box_blur_unit: top level, register file and size limits
// depends on dabb_pkg, dabb_if, dabb_ctrl, dabb_datapath
//
// req_chan takes one word per pixel (rgb and depth) in raster order, or a drain
// word that only moves the stream on. rsp_chan gives one word for each frame
// position, 4 rows plus 4 pixels behind the input (MAX_RADIUS rows and pixels);
// drain words flush the tail and frame_end marks the last pixel of a frame.
// csr_write_en with csr_index writes image_width, image_height or focus_depth;
// write them only while the unit is idle.
// one word is worked at a time: a word that causes no output goes through the
// multiply and lag check only; one that passes its pixel through adds a
// reciprocal multiply for the row slot, the centre read and the radius; a blurred
// pixel adds (2r+1)^2 window reads on the single line store read port and a
// serial division for the mean.
// reset clears all stream positions and loads the default frame size and
// focus; the line stores hold garbage until written.
// a stalled receiver holds rsp_chan; the unit keeps taking words until the next
// result is ready and then waits for the output register to empty.
module depth_adaptive_box_blur_unit import dabb_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_RADIUS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   dabb_req_if.sink               req_chan,
   dabb_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int W_W = $clog2(MAX_WIDTH + 1);

   logic [WIDTH_REG_W-1:0] width_ff;
   logic [ROW_W-1:0]       height_ff;
   logic [DEPTH_W-1:0]     focus_ff;
   logic [W_W-1:0]         img_width;
   logic [ROW_W-1:0]       img_height;
   dabb_cmd_type           cmd;
   dabb_status_type        status;
   logic                   req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         focus_ff  <= FOCUS_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[ROW_W-1:0];
            CSR_FOCUS_DEPTH:  focus_ff  <= csr_write_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(width_ff) < 32'(MIN_SIZE)) begin
         img_width = W_W'(MIN_SIZE);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         img_width = W_W'(MAX_WIDTH);
      end else begin
         img_width = W_W'(width_ff);
      end
      if (32'(height_ff) < 32'(MIN_SIZE)) begin
         img_height = ROW_W'(MIN_SIZE);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         img_height = ROW_W'(MAX_HEIGHT);
      end else begin
         img_height = height_ff;
      end
   end

   assign req_chan.ready = cmd.ready;
   assign req_accept     = req_chan.valid && cmd.ready;

   dabb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   dabb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .img_width     (img_width),
      .img_height    (img_height),
      .focus         (focus_ff),
      .req_accept    (req_accept),
      .req_mode      (req_chan.mode),
      .req_red       (req_chan.red_in),
      .req_green     (req_chan.green_in),
      .req_blue      (req_chan.blue_in),
      .req_depth     (req_chan.pixel_depth),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_red       (rsp_chan.red_out),
      .rsp_green     (rsp_chan.green_out),
      .rsp_blue      (rsp_chan.blue_out),
      .rsp_frame_end (rsp_chan.frame_end)
   );

endmodule
